// ===== rtl/core/b2da_pkg.sv =====
// shared types, constants and the double-dabble step for the decimal digit core
package b2da_pkg;

    // widths of the beat fields
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;

    // digit buffer depth and decimal digits a full-width value can need
    localparam int MAX_DIGITS = 10;
    localparam int BCD_DIGITS = 10;
    localparam int BUF_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
    localparam int IDX_W      = (BUF_DIGITS > 1) ? $clog2(BUF_DIGITS) : 1;
    localparam int TOP_W      = $clog2(BCD_DIGITS);

    // shift-add-3 pipeline shape
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    typedef logic [3:0]                  t_digit;
    typedef t_digit [BCD_DIGITS-1:0]     t_bcd;
    typedef t_digit [BUF_DIGITS-1:0]     t_buf;
    typedef logic [VALUE_W-1:0]          t_value;
    typedef logic [IDX_W-1:0]            t_idx;

    // working word of the conversion: bcd on top, remaining binary below
    typedef struct packed {
        t_bcd   bcd;
        t_value bin;
    } t_dab;

    // converted beat leaving the pipeline
    typedef struct packed {
        logic valid;
        t_bcd bcd;
    } t_conv;

    // one pipeline stage worth of double-dabble steps
    function automatic t_dab dabble_steps(input t_dab d);
        t_dab r;
        r = d;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int j = 0; j < BCD_DIGITS; j++) begin
                if (r.bcd[j] >= 4'd5) begin
                    r.bcd[j] = r.bcd[j] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/binary_to_decimal_ascii_digits_core.sv =====
// binary to decimal ascii digit core: top level with digit count and emitter
// the start beat passes 8 bcd stages, one count stage, then the emitter, which
// may hold the count stage while a number is emitting; digits follow one per cycle
// numbers overlap in the pipeline; the emitter takes the next one on the last digit
// reset: synchronous active-low reset empties all stages; results cannot stall
module binary_to_decimal_ascii_digits_core import b2da_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [VALUE_W-1:0] i_value,
    output logic              busy,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last
);

    t_conv conv;
    logic  dab_ready;
    logic  cen;
    logic  em_ready;

    logic  r_cv;
    t_buf  r_cdig;
    t_idx  r_cn;
    t_idx  n_cn;
    logic [TOP_W-1:0] top;

    logic  r_ev;
    logic  n_ev;
    t_buf  r_edig;
    t_idx  r_eidx;
    t_idx  n_eidx;

    // emitter takes a new number when idle or on its last digit
    assign em_ready = !r_ev || (r_eidx == '0);
    assign cen      = !r_cv || em_ready;
    assign busy     = !dab_ready;

    b2da_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (start && dab_ready),
        .i_value (i_value),
        .i_ready (cen),
        .o_ready (dab_ready),
        .o_conv  (conv)
    );

    // position of the leading non-zero digit, clipped to the buffer
    always_comb begin
        top = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (conv.bcd[i] != '0) begin
                top = TOP_W'(i);
            end
        end
        if (top > TOP_W'(BUF_DIGITS - 1)) begin
            n_cn = IDX_W'(BUF_DIGITS - 1);
        end else begin
            n_cn = IDX_W'(top);
        end
    end

    // count stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (cen) begin
            r_cv <= conv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cen) begin
            r_cdig <= conv.bcd[BUF_DIGITS-1:0];
            r_cn   <= n_cn;
        end
    end

    // emitter next state: load a number or step down one digit
    always_comb begin
        n_ev   = r_ev;
        n_eidx = r_eidx;
        if (em_ready && r_cv) begin
            n_ev   = 1'b1;
            n_eidx = r_cn;
        end else if (r_ev) begin
            if (r_eidx == '0) begin
                n_ev = 1'b0;
            end else begin
                n_eidx = r_eidx - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else begin
            r_ev <= n_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eidx <= n_eidx;
        if (em_ready && r_cv) begin
            r_edig <= r_cdig;
        end
    end

    // result beat
    assign o_strobe     = r_ev;
    assign o_digit_char = ASCII_ZERO + {2'b00, r_edig[r_eidx]};
    assign o_last       = r_ev && (r_eidx == '0);

`ifndef ASSERT_OFF
    // a number's digits come out without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("digit stream broke before the last digit");

    // every emitted code is a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_char >= ASCII_ZERO) &&
                     (o_digit_char <= ASCII_ZERO + CHAR_W'(9)))
        else $error("emitted code is not a decimal digit");

    // a full pipe behind a busy emitter must refuse new numbers
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev && (r_eidx != '0) && r_cv && conv.valid |-> busy)
        else $error("start taken while the pipe was full");

    // a waiting count stage is handed to the emitter as soon as it frees up
    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv && o_last |=> o_strobe)
        else $error("waiting number not handed to the emitter");
`endif

endmodule

// ===== rtl/core/b2da_dabble.sv =====
// pipelined binary to bcd conversion, a few shift-add-3 steps per stage
module b2da_dabble import b2da_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_value i_value,
    input  logic   i_ready,
    output logic   o_ready,
    output t_conv  o_conv
);

    logic r_valid [NUM_STAGES];
    t_dab r_dab   [NUM_STAGES];
    t_dab n_dab   [NUM_STAGES];
    logic en;

    // whole pipe moves when its last stage is empty or being drained
    assign en      = !r_valid[NUM_STAGES-1] || i_ready;
    assign o_ready = en;

    // next contents of every stage
    always_comb begin
        n_dab[0] = dabble_steps('{bcd: '0, bin: i_value});
        for (int s = 1; s < NUM_STAGES; s++) begin
            n_dab[s] = dabble_steps(r_dab[s-1]);
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (en) begin
            r_valid[0] <= i_load;
            for (int s = 1; s < NUM_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NUM_STAGES; s++) begin
                r_dab[s] <= n_dab[s];
            end
        end
    end

    assign o_conv.valid = r_valid[NUM_STAGES-1];
    assign o_conv.bcd   = r_dab[NUM_STAGES-1].bcd;

endmodule

// ===== tb/sv/binary_to_decimal_ascii_digits_checker.sv =====
// checker for the decimal digit core: predicts the digit beats of every number and compares
module binary_to_decimal_ascii_digits_checker import b2da_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  t_value            i_value,
    input  logic              i_strobe,
    input  logic [CHAR_W-1:0] i_digit_char,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_numbers,
    output int                o_digits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIX      = 10;
    localparam int PRINT_CAP  = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_digit_beat;

    // digits still owed by the block, oldest first
    t_digit_beat owed_digits [$];
    int          fail_total = 0;
    int          numbers_taken = 0;
    int          digits_matched = 0;

    // one line per mismatch, quiet after the first 20
    task automatic report_mismatch(input string what);
        fail_total++;
        if (fail_total <= PRINT_CAP) begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    // split a number into decimal digits, least significant first, then queue msd first
    task automatic queue_digits(input t_value number);
        t_digit      split [MAX_DIGITS];
        t_value      rest;
        int          count;
        t_digit_beat beat;
        rest  = number;
        count = 0;
        if (rest == '0) begin
            split[0] = '0;
            count    = 1;
        end else begin
            while (rest != '0 && count < MAX_DIGITS) begin
                split[count] = t_digit'(rest % RADIX);
                rest         = rest / RADIX;
                count++;
            end
        end
        for (int k = count - 1; k >= 0; k--) begin
            beat.digit_char = CHAR_W'(ASCII_ZERO + split[k]);
            beat.last       = (k == 0);
            owed_digits.push_back(beat);
        end
    endtask

    // watch both channels at every edge
    always @(posedge i_clk) begin
        t_digit_beat want;
        if (i_rst_n) begin
            if ($isunknown(i_busy) && i_start) begin
                report_mismatch("busy unknown while start is high");
            end
            if (i_start && i_busy === 1'b0) begin
                queue_digits(i_value);
                numbers_taken++;
            end
            if ($isunknown(i_strobe)) begin
                report_mismatch("digit strobe unknown");
            end else if (i_strobe) begin
                if (owed_digits.size() == 0) begin
                    report_mismatch($sformatf("digit beat 0x%0h last %b with nothing owed",
                                              i_digit_char, i_last));
                end else begin
                    want = owed_digits.pop_front();
                    if (i_digit_char !== want.digit_char) begin
                        report_mismatch($sformatf("digit_char 0x%0h, wanted 0x%0h",
                                                  i_digit_char, want.digit_char));
                    end
                    if (i_last !== want.last) begin
                        report_mismatch($sformatf("last %b, wanted %b on digit 0x%0h",
                                                  i_last, want.last, want.digit_char));
                    end
                    digits_matched++;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= owed_digits.size();
        o_numbers    <= numbers_taken;
        o_digits     <= digits_matched;
    end

endmodule

// ===== tb/sv/binary_to_decimal_ascii_digits_core_test.sv =====
// testbench top for the decimal digit core: clock, reset, number stimulus and verdict
module binary_to_decimal_ascii_digits_core_test import b2da_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 410;
    localparam int SEGMENT_LEN  = 40;
    localparam int TAIL_CYCLES  = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [63:0] VALUE_MAX = 64'hFFFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    t_value            i_value;
    logic              busy;
    logic              o_strobe;
    logic [CHAR_W-1:0] o_digit_char;
    logic              o_last;

    int chk_fail_count;
    int chk_pending;
    int chk_numbers;
    int chk_digits;
    int cycle_count = 0;
    int directed_sent = 0;
    int random_sent = 0;
    int drains = 0;

    // edge values, powers of ten, inner zeros and alternating bit patterns
    t_value directed_values [$] = {
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000,
        32'd90909, 32'd1000000, 32'd7000007, 32'd99999999, 32'd100000000,
        32'd999999999, 32'd1000000000, 32'd1000000001, 32'd2147483647,
        32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4294967294, 32'd4294967295
    };

    binary_to_decimal_ascii_digits_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .busy         (busy),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    binary_to_decimal_ascii_digits_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_strobe     (o_strobe),
        .i_digit_char (o_digit_char),
        .i_last       (o_last),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_numbers    (chk_numbers),
        .o_digits     (chk_digits)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digits still owed", cycle_count, chk_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // hold one number on the command port until the core takes it
    task automatic send_number(input t_value number);
        start   <= 1'b1;
        i_value <= number;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // idle the command port with noise on the value
    task automatic idle_cycles(input int count);
        if (count > 0) begin
            start   <= 1'b0;
            i_value <= $urandom;
            repeat (count) @(posedge i_clk);
        end
    endtask

    // stop sending until every owed digit has come out
    task automatic drain_digits();
        start   <= 1'b0;
        i_value <= $urandom;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        drains++;
    endtask

    // mostly back to back, often short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // numbers spread evenly over digit counts, some with many zero digits, some raw words
    function automatic t_value random_number();
        int          len;
        int          mode;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] built;
        mode = $urandom_range(0, 4);
        if (mode == 0) return $urandom;
        len = $urandom_range(1, 10);
        if (mode == 1) begin
            built = $urandom_range(1, 9);
            repeat (len - 1) begin
                built = built * 10 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 9));
            end
            return t_value'(built);
        end
        lo = 1;
        repeat (len - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1) lo = 0;
        if (hi > VALUE_MAX) hi = VALUE_MAX;
        return $urandom_range(hi[31:0], lo[31:0]);
    endfunction

    // stimulus and verdict
    initial begin
        bit no_gaps;
        start   <= 1'b0;
        i_value <= '0;
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed numbers
        foreach (directed_values[i]) begin
            send_number(directed_values[i]);
            directed_sent++;
            idle_cycles($urandom_range(0, 3));
        end
        drain_digits();

        // random numbers in segments, some segments with no gaps at all
        no_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            send_number(random_number());
            random_sent++;
            if (!no_gaps) begin
                idle_cycles(pick_gap());
            end
            if (n % 150 == 75) begin
                drain_digits();
            end
        end

        // wait for the last digits, then let the pipeline settle
        drain_digits();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d numbers (%0d directed, %0d random), %0d digit beats checked,",
                 chk_numbers, directed_sent, random_sent, chk_digits);
        $display("digit counts 1 to 10 with gaps, back-to-back runs and %0d full drains", drains);
        if (chk_pending != 0) begin
            $display("ERROR: %0d digits never arrived", chk_pending);
        end
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
